### design/postfix_stack_evaluator_defines.svh
// assertion helpers for the postfix evaluator
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/pse_pkg.sv
`default_nettype none
package pse_pkg;
    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DIV0  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_ADD   = 8'h2b;
    localparam logic [7:0] CH_SUB   = 8'h2d;
    localparam logic [7:0] CH_MUL   = 8'h2a;
    localparam logic [7:0] CH_DIV   = 8'h2f;
    localparam logic [7:0] CH_POW   = 8'h5e;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_AND   = 8'h26;
    localparam logic [7:0] CH_OR    = 8'h7c;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD, OP_POW, OP_AND, OP_OR
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic       load_ch;
        logic       acc_digit;
        logic       push;
        logic       rd_top;
        logic       rd_next;
        logic       alu_start;
        logic       write_res;
        logic       finish;
        logic       set_err;
        logic [2:0] err;
        op_t        op;
        logic       is_mod;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic alu_done;
        logic r_zero;
    } dp_stat_t;
endpackage
`default_nettype wire

### design/pse_alu.sv
`default_nettype none
module pse_alu
    import pse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire op_t         op,
    input  wire logic        is_mod,
    input  wire logic [31:0] l,
    input  wire logic [31:0] r,
    output logic             done,
    output logic [31:0]      res
);
    typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW, A_FIX} astate_t;
    astate_t st_reg;
    logic [31:0] a_reg, b_reg, acc_reg, rem_reg;
    logic [4:0]  cnt_reg;
    logic        ln_reg, rn_reg, done_reg;
    logic [31:0] res_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] la, ra;

    assign la = l[31] ? (32'd0 - l) : l;
    assign ra = r[31] ? (32'd0 - r) : r;
    assign rem_sh = {rem_reg[30:0], a_reg[31]};
    assign trial = {1'b0, rem_sh} - {1'b0, b_reg};
    assign done = done_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        case (op)
                            OP_ADD: begin res_reg <= l + r; done_reg <= 1'b1; end
                            OP_SUB: begin res_reg <= l - r; done_reg <= 1'b1; end
                            OP_MUL: begin res_reg <= l * r; done_reg <= 1'b1; end
                            OP_AND:
                            begin
                                res_reg  <= {31'd0, (l != 0) && (r != 0)};
                                done_reg <= 1'b1;
                            end
                            OP_OR:
                            begin
                                res_reg  <= {31'd0, (l != 0) || (r != 0)};
                                done_reg <= 1'b1;
                            end
                            OP_POW:
                            begin
                                if (r[31] || r == 0)
                                begin
                                    res_reg  <= 32'd1;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    a_reg   <= l;
                                    b_reg   <= r;
                                    acc_reg <= 32'd1;
                                    st_reg  <= A_POW;
                                end
                            end
                            default:
                            begin
                                a_reg   <= la;
                                b_reg   <= ra;
                                rem_reg <= '0;
                                ln_reg  <= l[31];
                                rn_reg  <= r[31];
                                cnt_reg <= '0;
                                st_reg  <= A_DIV;
                            end
                        endcase
                    end
                end
                A_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (!trial[32])
                    begin
                        rem_reg <= trial[31:0];
                        a_reg   <= {a_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        a_reg   <= {a_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        st_reg <= A_FIX;
                end
                A_POW:
                begin
                    // square and multiply, one exponent bit per step
                    if (b_reg[0])
                        acc_reg <= acc_reg * a_reg;
                    a_reg <= a_reg * a_reg;
                    b_reg <= {1'b0, b_reg[31:1]};
                    if (b_reg[31:1] == 0)
                        st_reg <= A_FIX;
                end
                A_FIX:
                begin
                    if (op == OP_POW)
                        res_reg <= acc_reg;
                    else if (is_mod)
                        res_reg <= ln_reg ? (32'd0 - rem_reg) : rem_reg;
                    else
                        res_reg <= (ln_reg != rn_reg) ? (32'd0 - a_reg) : a_reg;
                    done_reg <= 1'b1;
                    st_reg   <= A_IDLE;
                end
                default: st_reg <= A_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/pse_datapath.sv
`default_nettype none
module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire in_item_t                          in_item,
    input  wire dp_cmd_t                           cmd,
    output dp_stat_t                               stat,
    output logic [7:0]                             ch,
    output logic                                   ch_last,
    output logic                                   in_num,
    output logic [$clog2(STACK_DEPTH+1)-1:0]       count,
    output logic [2:0]                             err,
    output out_item_t                              result
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [31:0] mem [STACK_DEPTH];
    logic [7:0]  ch_reg;
    logic        last_reg, in_num_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  err_reg;
    logic [31:0] acc_reg, top_reg, rd_data;
    logic [31:0] alu_res;
    logic        alu_done;
    logic [AW-1:0] rd_addr;
    out_item_t   res_reg;
    logic [CW-1:0] cm1, cm2;

    assign cm1 = cnt_reg - CW'(1);
    assign cm2 = cnt_reg - CW'(2);
    assign rd_addr = cmd.rd_top ? cm1[AW-1:0] : cm2[AW-1:0];
    assign ch = ch_reg;
    assign ch_last = last_reg;
    assign in_num = in_num_reg;
    assign count = cnt_reg;
    assign err = err_reg;
    assign result = res_reg;
    assign stat.alu_done = alu_done;
    assign stat.r_zero = (top_reg == 32'd0);

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (cmd.push && cnt_reg != FULL)
            mem[cnt_reg[AW-1:0]] <= acc_reg;
        else if (cmd.write_res)
            mem[cm2[AW-1:0]] <= alu_res;
    end

    // left operand sits on the read port in the cycle of the start
    pse_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .op     (cmd.op),
        .is_mod (cmd.is_mod),
        .l      (rd_data),
        .r      (top_reg),
        .done   (alu_done),
        .res    (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            acc_reg    <= '0;
            in_num_reg <= 1'b0;
            err_reg    <= ST_OK;
        end
        else
        begin
            if (cmd.acc_digit)
            begin
                acc_reg    <= (acc_reg << 3) + (acc_reg << 1) + {24'd0, ch_reg - CH_0};
                in_num_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                acc_reg    <= '0;
                in_num_reg <= 1'b0;
                if (cnt_reg != FULL)
                    cnt_reg <= cnt_reg + CW'(1);
                else if (err_reg == ST_OK)
                    err_reg <= ST_OVER;
            end
            if (cmd.set_err && err_reg == ST_OK)
                err_reg <= cmd.err;
            if (cmd.write_res)
                cnt_reg <= cm1;
            if (cmd.finish)
            begin
                cnt_reg <= '0;
                err_reg <= ST_OK;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_ch)
        begin
            ch_reg   <= in_item.char_in;
            last_reg <= in_item.last;
        end
        if (cmd.rd_next)
            top_reg <= rd_data;
        if (cmd.finish)
        begin
            if (err_reg != ST_OK)
            begin
                res_reg.value  <= '0;
                res_reg.status <= err_reg;
            end
            else if (cnt_reg == 0)
            begin
                res_reg.value  <= '0;
                res_reg.status <= ST_EMPTY;
            end
            else
            begin
                res_reg.value  <= rd_data;
                res_reg.status <= ST_OK;
            end
        end
    end
endmodule
`default_nettype wire

### design/pse_ctrl.sv
`default_nettype none
module pse_ctrl
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    input  wire logic [7:0]                  ch,
    input  wire logic                        ch_last,
    input  wire logic                        in_num,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0] count,
    input  wire dp_stat_t                    stat,
    output dp_cmd_t                          cmd
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_TOP, S_RD_NXT, S_CHK, S_ALU, S_END_PUSH,
        S_END_RD, S_END_WAIT, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_digit, is_op, op_mod;
    op_t    op;

    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    always_comb
    begin
        is_op  = 1'b1;
        op     = OP_ADD;
        op_mod = 1'b0;
        case (ch)
            CH_ADD: op = OP_ADD;
            CH_SUB: op = OP_SUB;
            CH_MUL: op = OP_MUL;
            CH_DIV: op = OP_DIVMOD;
            CH_MOD: begin op = OP_DIVMOD; op_mod = 1'b1; end
            CH_POW: op = OP_POW;
            CH_AND: op = OP_AND;
            CH_OR:  op = OP_OR;
            default: is_op = 1'b0;
        endcase
    end

    // a waiting result only holds the final state, items keep entering
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op;
        cmd.is_mod     = op_mod;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_ch = in_valid && in_ready;
                if (in_valid && in_ready)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (is_digit)
                begin
                    cmd.acc_digit = 1'b1;
                    state_next = ch_last ? S_END_PUSH : S_IDLE;
                end
                else if (in_num)
                begin
                    cmd.push = 1'b1;
                    state_next = S_RD_TOP;
                end
                else
                    state_next = S_RD_TOP;
            end
            S_RD_TOP:
            begin
                cmd.rd_top = 1'b1;
                if (!is_op || count == 0)
                    state_next = ch_last ? S_END_RD : S_IDLE;
                else if (count == CW'(1))
                begin
                    cmd.set_err = 1'b1;
                    cmd.err = ST_UNDER;
                    state_next = ch_last ? S_END_RD : S_IDLE;
                end
                else
                    state_next = S_RD_NXT;
            end
            S_RD_NXT:
            begin
                cmd.rd_next = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (op == OP_DIVMOD && stat.r_zero)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err = ST_DIV0;
                    state_next = ch_last ? S_END_RD : S_IDLE;
                end
                else
                begin
                    cmd.alu_start = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                if (stat.alu_done)
                begin
                    cmd.write_res = 1'b1;
                    state_next = ch_last ? S_END_RD : S_IDLE;
                end
            end
            S_END_PUSH:
            begin
                cmd.push = 1'b1;
                state_next = S_END_RD;
            end
            S_END_RD:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_END_WAIT;
            end
            S_END_WAIT:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // keep the top entry on the read port while the result waits
                cmd.rd_top = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

### design/postfix_stack_evaluator.sv
// per item the controller steps through idle and decode; separators add read top,
// operators add read top, read next, check and alu (alu iterations dominate divide,
// modulo and power); the last item then runs end read, end wait and fin first
// throughput: one item at a time through the controller fsm, one stack ram port;
// a result not yet taken holds the next last item in its final cycle
// reset: rst_n asynchronous, clears count, accumulator, error and control
`default_nettype none
`include "postfix_stack_evaluator_defines.svh"
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [7:0]    ch;
    logic          ch_last, in_num;
    logic [CW-1:0] count;
    logic [2:0]    err;

    pse_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ch        (ch),
        .ch_last   (ch_last),
        .in_num    (in_num),
        .count     (count),
        .stat      (stat),
        .cmd       (cmd)
    );

    pse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .ch      (ch),
        .ch_last (ch_last),
        .in_num  (in_num),
        .count   (count),
        .err     (err),
        .result  (out_data)
    );

    `PSE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count <= CW'(STACK_DEPTH))
    `PSE_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.finish, count == 0 && err == ST_OK)
    `PSE_ASSERT_IMPL(a_err_value_zero, clk, rst_n, out_valid && out_data.status != ST_OK,
                     out_data.value == 0)
endmodule
`default_nettype wire

### dv/postfix_checker.sv
`timescale 1ns / 1ps
module postfix_checker
    import pse_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data,
    output int             fail_count,
    output int             pending,
    output int             results_seen,
    output int             err_seen
);
    logic [31:0] stk [DEPTH];
    int          depth_used;
    logic [31:0] accum;
    logic        digit_open;
    logic [2:0]  first_err;
    out_item_t   expected_q [$];

    function automatic logic [31:0] wrap_pow(logic [31:0] b, logic [31:0] e);
        logic [31:0] acc;
        acc = 32'd1;
        if (e[31])
            return 32'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = acc * b;
            b = b * b;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic is_operator(logic [7:0] c);
        return c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
               c == CH_POW || c == CH_MOD || c == CH_AND || c == CH_OR;
    endfunction

    task automatic flag(logic [2:0] code);
        if (first_err == ST_OK)
            first_err = code;
    endtask

    task automatic push_num(logic [31:0] v);
        if (depth_used >= DEPTH)
            flag(ST_OVER);
        else
        begin
            stk[depth_used] = v;
            depth_used++;
        end
    endtask

    task automatic apply_operator(logic [7:0] c);
        logic [31:0] r, l, res, la, ra, q, m;
        if (depth_used == 0)
            return;
        if (depth_used == 1)
        begin
            flag(ST_UNDER);
            return;
        end
        r = stk[depth_used - 1];
        l = stk[depth_used - 2];
        if ((c == CH_DIV || c == CH_MOD) && r == 0)
        begin
            flag(ST_DIV0);
            return;
        end
        case (c)
            CH_ADD: res = l + r;
            CH_SUB: res = l - r;
            CH_MUL: res = l * r;
            CH_POW: res = wrap_pow(l, r);
            CH_AND: res = (l != 0 && r != 0) ? 32'd1 : 32'd0;
            CH_OR:  res = (l != 0 || r != 0) ? 32'd1 : 32'd0;
            default:
            begin
                la = l[31] ? -l : l;
                ra = r[31] ? -r : r;
                q = la / ra;
                m = la % ra;
                if (c == CH_DIV)
                    res = (l[31] != r[31]) ? -q : q;
                else
                    res = l[31] ? -m : m;
            end
        endcase
        depth_used--;
        stk[depth_used - 1] = res;
    endtask

    task automatic eval_char(in_item_t it);
        out_item_t e;
        if (it.char_in >= CH_0 && it.char_in <= CH_9)
        begin
            accum = accum * 32'd10 + 32'(it.char_in - CH_0);
            digit_open = 1'b1;
        end
        else
        begin
            if (digit_open)
            begin
                push_num(accum);
                accum = 0;
                digit_open = 1'b0;
            end
            if (is_operator(it.char_in))
                apply_operator(it.char_in);
        end
        if (!it.last)
            return;
        if (digit_open)
            push_num(accum);
        if (first_err != ST_OK)
        begin
            e.value = 0;
            e.status = first_err;
        end
        else if (depth_used == 0)
        begin
            e.value = 0;
            e.status = ST_EMPTY;
        end
        else
        begin
            e.value = stk[depth_used - 1];
            e.status = ST_OK;
        end
        expected_q.push_back(e);
        depth_used = 0;
        accum = 0;
        digit_open = 1'b0;
        first_err = ST_OK;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        int        miss;
        if (!rst_n)
        begin
            depth_used = 0;
            accum = 0;
            digit_open = 1'b0;
            first_err = ST_OK;
            fail_count <= 0;
            results_seen <= 0;
            err_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                miss = 0;
                results_seen <= results_seen + 1;
                if (out_data.status != ST_OK)
                    err_seen <= err_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: value %0d status %0d",
                           out_data.value, out_data.status);
                    miss++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_data.value !== e.value)
                    begin
                        $error("value: expected %0d actual %0d", e.value, out_data.value);
                        miss++;
                    end
                    if (out_data.status !== e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status, out_data.status);
                        miss++;
                    end
                end
                fail_count <= fail_count + miss;
            end
            if (in_valid && in_ready)
                eval_char(in_data);
        end
    end

    assign pending = expected_q.size();
endmodule

### dv/tb_postfix_stack_evaluator.sv
`timescale 1ns / 1ps
module tb_postfix_stack_evaluator;
    import pse_pkg::*;

    localparam int DEPTH     = STACK_DEPTH_DEF;
    localparam int IDLE_MAX  = 5000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int fail_count, pending, results_seen, err_seen;
    int send_idle_pct, recv_idle_pct;
    logic hold_off;
    int chars_sent;
    int idle_cycles;

    postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    postfix_checker #(.DEPTH(DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .err_seen(err_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver readiness, redrawn every falling edge
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("[postfix_stack_evaluator] ERROR");
            $finish;
        end
    end

    // starts and ends at a falling edge; valid drops only while idling
    task automatic send_char(logic [7:0] c, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.char_in <= c;
        in_data.last <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_number(logic [31:0] n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_operator();
        logic [7:0] ops [8];
        ops = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW, CH_MOD, CH_AND, CH_OR};
        return ops[$urandom_range(7)];
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(3))
            0: return 8'h20;
            1: return 8'h2c;
            2: return 8'h61 + 8'($urandom_range(25));
            default: return 8'h41 + 8'($urandom_range(25));
        endcase
    endfunction

    // an expression of random numbers and operators that ends on an operator
    task automatic send_expression();
        int vals;
        int n_ops;
        vals = 0;
        n_ops = $urandom_range(1, 4);
        for (int k = 0; k < 2 * n_ops + 1; k++)
        begin
            if (vals < 2 || ($urandom_range(1) && k < n_ops + 1))
            begin
                if ($urandom_range(3) == 0)
                    send_number($urandom());
                else
                    send_number($urandom_range(12));
                send_char(pick_separator(), 1'b0);
                vals++;
            end
            else
            begin
                send_char(pick_operator(), 1'b0);
                vals--;
            end
        end
        send_char(pick_operator(), 1'b1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            send_char(8'($urandom()), k == n - 1);
    endtask

    task automatic random_phase(int count);
        int start;
        start = chars_sent;
        while (chars_sent - start < count)
        begin
            if ($urandom_range(9) < 8)
                send_expression();
            else
                send_noise();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        chars_sent = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 85;
        send_text("3 4+");
        send_text("2147483647 1+");
        send_text("7 0/");
        send_text("5 0%");
        send_text("5+");
        send_text("+9");
        send_text(" ");
        send_text("2 3 ^ 4 -5");
        send_text("2,4-0 10-^");
        send_text("4294967295 255*");
        send_text("2147483648 4294967295/");
        send_text("2147483648 4294967295%");
        send_text("0-7 2/ 0 7- 2%");
        send_text("0 3& 2 3&|");
        send_text("3a4*");
        send_text("9");
        // overflow: one more number than the stack holds
        for (int k = 0; k <= DEPTH; k++)
        begin
            send_number(32'(k % 7));
            send_char(8'h20, 1'b0);
        end
        send_text("1+");
        random_phase(150);

        // receiver blocks for a long while as characters keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_text("1 2+");
                send_text("3 4*");
                random_phase(60);
            end
        join

        send_idle_pct = 85;
        recv_idle_pct = 37;
        random_phase(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d characters, %0d expressions, %0d with error status",
                 chars_sent, results_seen, err_seen);
        if (fail_count == 0)
            $display("[postfix_stack_evaluator] OK");
        else
            $display("[postfix_stack_evaluator] ERROR");
        $finish;
    end
endmodule
